// ===== hdl/afxc_pkg.sv =====
// Shared constants, status codes and key table for the frame XOR codec.
package afxc_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int STATUS_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD  = 1'd1;

    localparam logic [STATUS_W-1:0] ST_OK       = 4'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 4'd1;
    localparam logic [STATUS_W-1:0] ST_MARKER   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_LENGTH   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_PADDING  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_SMALL    = 4'd5;
    localparam logic [STATUS_W-1:0] ST_NOFE     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_CHECKSUM = 4'd7;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 4'd8;

    localparam logic [7:0] BYTE_MARKER = 8'h01;
    localparam logic [7:0] BYTE_FE     = 8'hFE;
    localparam logic [7:0] BYTE_ZERO   = 8'h00;
    localparam logic [7:0] MIN_DLEN    = 8'd6;
    localparam logic [7:0] XOR_START   = 8'd6;

    function automatic logic [7:0] key_lookup(input logic [3:0] sel);
        logic [7:0] k;
        case (sel)
            4'h0:    k = 8'hCB;
            4'h1:    k = 8'h6A;
            4'h2:    k = 8'h95;
            4'h3:    k = 8'h8D;
            4'h4:    k = 8'hB6;
            4'h5:    k = 8'h7B;
            4'h6:    k = 8'h35;
            4'h7:    k = 8'h5A;
            4'h8:    k = 8'h6E;
            4'h9:    k = 8'h49;
            4'hA:    k = 8'h5C;
            4'hB:    k = 8'h85;
            4'hC:    k = 8'h37;
            4'hD:    k = 8'h3C;
            4'hE:    k = 8'hA6;
            default: k = 8'h88;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] make_check(input logic [7:0] sum);
        return ~(sum + 8'd1);
    endfunction

endpackage

// ===== hdl/afxc_if.sv =====
// Input and output stream interfaces of the frame XOR codec.
interface afxc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface afxc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [3:0] status;

    modport source (output valid, output out_byte, output out_last, output status,
                    input ready);
    modport sink (input valid, input out_byte, input out_last, input status,
                  output ready);
endinterface

// ===== hdl/adv_frame_xor_codec.sv =====
// Frame XOR codec: byte store, encode/decode sequencer and output register.
// Load: one byte per cycle, no input transfer while a frame is being processed.
// Encode: after the last byte, frame bytes leave through the read stage and output register,
// one per cycle while the output is ready. Decode: scan of bytes 2..size-1 at one per cycle,
// then checks; payload bytes (or a late error) then leave one per cycle while the output is ready.
// Reset is asynchronous active low; the byte store has no reset.
module adv_frame_xor_codec #(
    parameter int MAX_FRAME = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [afxc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afxc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    afxc_in_if.sink                        din,
    afxc_out_if.source                     dout
);
    import afxc_pkg::*;

    localparam int AW = $clog2(MAX_FRAME);
    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_FRAME);
    localparam logic [7:0]    MAX8 = 8'(MAX_FRAME);

    typedef enum logic [2:0] {S_IDLE, S_ENC, S_SCAN, S_CHECK, S_DEC, S_ERR} state_t;

    logic [7:0] mem [MAX_FRAME];
    logic [7:0] rd_data_reg;

    state_t        state_reg;
    logic          mode_reg;
    logic [5:0]    pad_reg;
    logic [CW-1:0] count_reg;
    logic [7:0]    sum_reg;
    logic          ov_reg;
    logic [7:0]    b0_reg, b1_reg, b2_reg, b4_reg;

    logic [CW-1:0] idx_reg, n_reg, total_reg;
    logic [7:0]    cs_reg, key_reg, dlen_reg;
    logic [3:0]    err_reg;
    logic          pad_err_reg;
    logic [7:0]    dsum_reg, crec_reg;

    logic          p_valid_reg, p_mem_reg, p_last_reg, p_scan_reg;
    logic [7:0]    p_const_reg, p_key_reg;
    logic [3:0]    p_status_reg;
    logic [CW-1:0] p_idx_reg;

    logic       o_valid_reg, o_last_reg;
    logic [7:0] o_byte_reg;
    logic [3:0] o_status_reg;

    logic acc, wr_en, cnt_full;
    logic [CW-1:0] n_fin;
    logic ov_fin, scan_go;
    logic [7:0] sum_fin, b0_fin, b1_fin, b2_fin;
    logic [7:0] pad8, clamp8, flen8, total8;

    logic p_move, can_issue;
    logic iss_valid, iss_mem, iss_last, iss_scan;
    logic [AW-1:0] iss_addr;
    logic [7:0] iss_const, iss_key;
    logic [3:0] iss_status;
    logic [7:0] scan_i8, scan_rec;

    assign acc      = din.valid & din.ready;
    assign cnt_full = (count_reg == MAXC);
    assign wr_en    = acc & ~cnt_full;
    assign n_fin    = cnt_full ? count_reg : count_reg + CW'(1);
    assign ov_fin   = ov_reg | cnt_full;
    assign sum_fin  = sum_reg + din.data_byte;
    assign b0_fin   = (count_reg == CW'(0)) ? din.data_byte : b0_reg;
    assign b1_fin   = (count_reg == CW'(1)) ? din.data_byte : b1_reg;
    assign b2_fin   = (count_reg == CW'(2)) ? din.data_byte : b2_reg;
    assign pad8     = {2'b00, pad_reg};
    assign clamp8   = (pad8 > MAX8) ? MAX8 : pad8;
    assign flen8    = 8'(n_fin) + 8'd3;
    assign total8   = (clamp8 > flen8) ? clamp8 : flen8;
    assign scan_go  = mode_reg & ~ov_fin & (n_fin >= CW'(2)) & (b1_fin == BYTE_MARKER)
                    & (8'(n_fin) > b0_fin) & (b0_fin != BYTE_ZERO);

    assign p_move    = p_valid_reg & (p_scan_reg | ~o_valid_reg | dout.ready);
    assign can_issue = ~p_valid_reg | p_move;

    assign scan_i8  = 8'(p_idx_reg);
    assign scan_rec = (scan_i8 >= XOR_START) ? (rd_data_reg ^ key_reg) : rd_data_reg;

    always_comb
    begin
        iss_valid  = 1'b0;
        iss_mem    = 1'b0;
        iss_addr   = AW'(idx_reg);
        iss_const  = BYTE_ZERO;
        iss_key    = BYTE_ZERO;
        iss_last   = 1'b0;
        iss_scan   = 1'b0;
        iss_status = ST_OK;
        case (state_reg)
            S_ENC:
            begin
                iss_valid = can_issue;
                iss_mem   = (idx_reg >= CW'(2)) && (idx_reg < n_reg + CW'(2));
                iss_addr  = AW'(idx_reg - CW'(2));
                if (idx_reg == CW'(0))
                    iss_const = 8'(n_reg) + 8'd2;
                else if (idx_reg == CW'(1))
                    iss_const = BYTE_MARKER;
                else if (idx_reg == n_reg + CW'(2))
                    iss_const = cs_reg;
                if ((idx_reg >= CW'(6)) && (idx_reg < n_reg + CW'(3)))
                    iss_key = key_reg;
                iss_last = (idx_reg == total_reg - CW'(1));
            end
            S_SCAN:
            begin
                iss_valid = can_issue && (idx_reg < count_reg);
                iss_mem   = 1'b1;
                iss_scan  = 1'b1;
            end
            S_DEC:
            begin
                iss_valid = can_issue;
                iss_mem   = 1'b1;
                if (8'(idx_reg) >= XOR_START)
                    iss_key = key_reg;
                iss_last = (8'(idx_reg) == dlen_reg - 8'd1);
            end
            S_ERR:
            begin
                iss_valid  = can_issue;
                iss_last   = 1'b1;
                iss_status = err_reg;
            end
            default:
            begin
                iss_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[AW'(count_reg)] <= din.data_byte;
        if (iss_valid && iss_mem)
            rd_data_reg <= mem[iss_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mode_reg     <= 1'b0;
            pad_reg      <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            ov_reg       <= 1'b0;
            b0_reg       <= '0;
            b1_reg       <= '0;
            b2_reg       <= '0;
            b4_reg       <= '0;
            idx_reg      <= '0;
            n_reg        <= '0;
            total_reg    <= '0;
            cs_reg       <= '0;
            key_reg      <= '0;
            dlen_reg     <= '0;
            err_reg      <= ST_OK;
            pad_err_reg  <= 1'b0;
            dsum_reg     <= '0;
            crec_reg     <= '0;
            p_valid_reg  <= 1'b0;
            p_mem_reg    <= 1'b0;
            p_last_reg   <= 1'b0;
            p_scan_reg   <= 1'b0;
            p_const_reg  <= '0;
            p_key_reg    <= '0;
            p_status_reg <= ST_OK;
            p_idx_reg    <= '0;
            o_valid_reg  <= 1'b0;
            o_last_reg   <= 1'b0;
            o_byte_reg   <= '0;
            o_status_reg <= ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE: mode_reg <= cfg_wdata[0];
                    CFG_PAD:  pad_reg  <= cfg_wdata;
                    default:  pad_reg  <= pad_reg;
                endcase
            end

            // load side
            if (acc)
            begin
                if (wr_en)
                begin
                    if (count_reg == CW'(0)) b0_reg <= din.data_byte;
                    if (count_reg == CW'(1)) b1_reg <= din.data_byte;
                    if (count_reg == CW'(2)) b2_reg <= din.data_byte;
                    if (count_reg == CW'(4)) b4_reg <= din.data_byte;
                end
                if (!din.last_byte)
                begin
                    sum_reg <= sum_fin;
                    if (wr_en)
                        count_reg <= count_reg + CW'(1);
                    else
                        ov_reg <= 1'b1;
                end
                else
                begin
                    sum_reg     <= '0;
                    ov_reg      <= 1'b0;
                    count_reg   <= scan_go ? n_fin : '0;  // scan bound, cleared again in check
                    n_reg       <= n_fin;
                    total_reg   <= CW'(total8);
                    cs_reg      <= make_check(sum_fin);
                    dlen_reg    <= b0_fin;
                    pad_err_reg <= 1'b0;
                    dsum_reg    <= '0;
                    crec_reg    <= '0;
                    idx_reg     <= mode_reg ? CW'(2) : CW'(0);
                    key_reg     <= key_lookup(mode_reg ? b2_fin[3:0] : b0_fin[3:0]);
                    if (!mode_reg)
                    begin
                        if (ov_fin || (flen8 > MAX8))
                        begin
                            err_reg   <= ST_OVERFLOW;
                            state_reg <= S_ERR;
                        end
                        else
                            state_reg <= S_ENC;
                    end
                    else
                    begin
                        state_reg <= scan_go ? S_SCAN : S_ERR;
                        if (ov_fin)
                            err_reg <= ST_OVERFLOW;
                        else if (n_fin < CW'(2))
                            err_reg <= ST_SHORT;
                        else if (b1_fin != BYTE_MARKER)
                            err_reg <= ST_MARKER;
                        else if (8'(n_fin) <= b0_fin)
                            err_reg <= ST_LENGTH;
                        else if (b0_fin == BYTE_ZERO)
                            err_reg <= ST_PADDING;  // marker byte falls in the padding
                    end
                end
            end

            // sequencer
            case (state_reg)
                S_ENC:
                begin
                    if (iss_valid)
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        if (iss_last)
                            state_reg <= S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    if (iss_valid)
                        idx_reg <= idx_reg + CW'(1);
                    else if ((idx_reg >= count_reg) && !p_valid_reg)
                        state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    count_reg <= '0;
                    idx_reg   <= CW'(2);
                    state_reg <= S_ERR;
                    if (pad_err_reg)
                        err_reg <= ST_PADDING;
                    else if (dlen_reg < MIN_DLEN)
                        err_reg <= ST_SMALL;
                    else if (b4_reg != BYTE_FE)
                        err_reg <= ST_NOFE;
                    else if (make_check(dsum_reg) != crec_reg)
                        err_reg <= ST_CHECKSUM;
                    else
                        state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    if (iss_valid)
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        if (iss_last)
                            state_reg <= S_IDLE;
                    end
                end
                S_ERR:
                begin
                    if (iss_valid)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                end
            endcase

            // read stage
            if (iss_valid)
            begin
                p_valid_reg  <= 1'b1;
                p_mem_reg    <= iss_mem;
                p_const_reg  <= iss_const;
                p_key_reg    <= iss_key;
                p_last_reg   <= iss_last;
                p_scan_reg   <= iss_scan;
                p_status_reg <= iss_status;
                p_idx_reg    <= idx_reg;
            end
            else if (p_move)
                p_valid_reg <= 1'b0;

            // scan pass: padding check and checksum of recovered bytes
            if (p_move && p_scan_reg)
            begin
                if (scan_i8 > dlen_reg)
                begin
                    if (rd_data_reg != BYTE_ZERO)
                        pad_err_reg <= 1'b1;
                end
                else if (scan_i8 == dlen_reg)
                    crec_reg <= scan_rec;
                else
                    dsum_reg <= dsum_reg + scan_rec;
            end

            // output register
            if (p_move && !p_scan_reg)
            begin
                o_valid_reg  <= 1'b1;
                o_byte_reg   <= (p_mem_reg ? rd_data_reg : p_const_reg) ^ p_key_reg;
                o_last_reg   <= p_last_reg;
                o_status_reg <= p_status_reg;
            end
            else if (dout.ready)
                o_valid_reg <= 1'b0;
        end
    end

    assign din.ready     = (state_reg == S_IDLE);
    assign dout.valid    = o_valid_reg;
    assign dout.out_byte = o_byte_reg;
    assign dout.out_last = o_last_reg;
    assign dout.status   = o_status_reg;

endmodule

// ===== bench/tb_adv_frame_xor_codec.sv =====
// Self-checking testbench for adv_frame_xor_codec: directed and random stream traffic against a frame predictor.
`timescale 1ns / 100ps

module tb_adv_frame_xor_codec;
    import afxc_pkg::*;

    localparam int          FRAME_MAX     = 32;
    localparam int          RANDOM_ITEMS  = 320;
    localparam int          PHASE_BYTES   = 40;
    localparam int          SETTLE_CYCLES = 3 * FRAME_MAX + 8;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          LIMIT_CYCLES  = 800000;
    localparam int          MAX_REPORTS   = 50;
    localparam int unsigned XOR_FROM      = 6;
    localparam bit          MODE_ENCODE   = 1'b0;
    localparam bit          MODE_DECODE   = 1'b1;

    localparam logic [7:0] KEY_TABLE [16] = '{
        8'hCB, 8'h6A, 8'h95, 8'h8D, 8'hB6, 8'h7B, 8'h35, 8'h5A,
        8'h6E, 8'h49, 8'h5C, 8'h85, 8'h37, 8'h3C, 8'hA6, 8'h88
    };

    typedef logic [7:0] byte_q_t [$];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    typedef struct packed {
        logic [7:0]          value;
        logic                last;
        logic [STATUS_W-1:0] status;
    } codec_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic       send_valid = 1'b0;
    logic [7:0] send_data  = 8'h00;
    logic       send_last  = 1'b0;
    logic       recv_ready = 1'b0;
    logic       hold_active = 1'b0;

    bit send_burst = 1'b0;
    bit recv_burst = 1'b0;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // frame capture state and configuration as the block should hold them
    logic [7:0]  frame_bytes [FRAME_MAX];
    int unsigned frame_len = 0;
    bit          frame_overflow = 1'b0;
    bit          cur_mode = MODE_ENCODE;
    logic [5:0]  cur_pad = 6'd0;

    stream_byte_t  pending_bytes [$];
    codec_result_t pending_results [$];

    event hold_go;

    afxc_in_if  in_bus ();
    afxc_out_if out_bus ();

    assign in_bus.valid     = send_valid;
    assign in_bus.data_byte = send_data;
    assign in_bus.last_byte = send_last;
    assign out_bus.ready    = recv_ready;

    adv_frame_xor_codec #(
        .MAX_FRAME(FRAME_MAX)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .din      (in_bus),
        .dout     (out_bus)
    );

    always #6 clk = ~clk;

    function automatic int unsigned pick_gap(input bit burst);
        int unsigned r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(15, 30);
    endfunction

    function automatic void rand_bytes(input int unsigned n, output byte_q_t q);
        q.delete();
        repeat (n)
            q.insert(q.size(), 8'($urandom_range(0, 255)));
    endfunction

    // Encoded frame of a payload: length, marker, payload, checksum, keyed tail, zero pad.
    function automatic void build_frame(input byte_q_t payload, input int unsigned pad,
                                        output byte_q_t frame);
        int unsigned n, flen, total, i;
        logic [7:0]  sum, key, b, first;
        n = payload.size();
        flen = n + 3;
        sum = 8'h00;
        foreach (payload[j])
            sum += payload[j];
        first = payload[0];
        key = KEY_TABLE[first[3:0]];
        total = (pad > FRAME_MAX) ? FRAME_MAX : pad;
        if (total < flen)
            total = flen;
        frame.delete();
        for (i = 0; i < total; i++)
        begin
            if (i == 0)
                b = 8'(n + 2);
            else if (i == 1)
                b = BYTE_MARKER;
            else if (i < n + 2)
                b = payload[i - 2];
            else if (i == n + 2)
                b = (sum + 8'd1) ^ 8'hFF;
            else
                b = BYTE_ZERO;
            if (i >= XOR_FROM && i < flen)
                b ^= key;
            frame.insert(frame.size(), b);
        end
    endfunction

    function automatic void push_result(input logic [7:0] value, input logic last,
                                        input logic [STATUS_W-1:0] status);
        pending_results.insert(pending_results.size(), codec_result_t'{value, last, status});
    endfunction

    function automatic void encode_results();
        byte_q_t payload, frame;
        if (frame_overflow || frame_len + 3 > FRAME_MAX)
        begin
            push_result(8'h00, 1'b1, ST_OVERFLOW);
            return;
        end
        for (int unsigned i = 0; i < frame_len; i++)
            payload.insert(payload.size(), frame_bytes[i]);
        build_frame(payload, cur_pad, frame);
        foreach (frame[i])
            push_result(frame[i], i == frame.size() - 1, ST_OK);
    endfunction

    function automatic void decode_results();
        int unsigned dlen, i;
        logic [7:0]  key, sum, b, check, sel;
        logic [7:0]  rec [FRAME_MAX];
        if (frame_overflow)
        begin
            push_result(8'h00, 1'b1, ST_OVERFLOW);
            return;
        end
        if (frame_len < 2)
        begin
            push_result(8'h00, 1'b1, ST_SHORT);
            return;
        end
        dlen = frame_bytes[0];
        if (frame_bytes[1] != BYTE_MARKER)
        begin
            push_result(8'h00, 1'b1, ST_MARKER);
            return;
        end
        if (frame_len < dlen + 1)
        begin
            push_result(8'h00, 1'b1, ST_LENGTH);
            return;
        end
        for (i = dlen + 1; i < frame_len; i++)
        begin
            if (frame_bytes[i] != BYTE_ZERO)
            begin
                push_result(8'h00, 1'b1, ST_PADDING);
                return;
            end
        end
        if (dlen < 6)
        begin
            push_result(8'h00, 1'b1, ST_SMALL);
            return;
        end
        if (frame_bytes[4] != BYTE_FE)
        begin
            push_result(8'h00, 1'b1, ST_NOFE);
            return;
        end
        sel = frame_bytes[2];
        key = KEY_TABLE[sel[3:0]];
        sum = 8'h00;
        for (i = 2; i <= dlen; i++)
        begin
            b = frame_bytes[i];
            if (i >= XOR_FROM)
                b ^= key;
            rec[i] = b;
            if (i < dlen)
                sum += b;
        end
        check = (sum + 8'd1) ^ 8'hFF;
        if (check != rec[dlen])
        begin
            push_result(8'h00, 1'b1, ST_CHECKSUM);
            return;
        end
        for (i = 2; i < dlen; i++)
            push_result(rec[i], i + 1 == dlen, ST_OK);
    endfunction

    function automatic void store_byte(input logic [7:0] data, input logic last);
        if (frame_len < FRAME_MAX)
        begin
            frame_bytes[frame_len] = data;
            frame_len++;
        end
        else
            frame_overflow = 1'b1;
        if (!last)
            return;
        if (cur_mode == MODE_DECODE)
            decode_results();
        else
            encode_results();
        frame_len = 0;
        frame_overflow = 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // input driver
    always @(posedge clk)
    begin
        stream_byte_t next_item;
        if (rst_n)
        begin
            if (send_valid && in_bus.ready)
                store_byte(send_data, send_last);
            if (!send_valid || in_bus.ready)
            begin
                if (send_wait != 0 || pending_bytes.size() == 0)
                begin
                    send_valid <= 1'b0;
                    if (send_wait != 0)
                        send_wait--;
                end
                else
                begin
                    next_item = pending_bytes.pop_front();
                    send_valid <= 1'b1;
                    send_data  <= next_item.data;
                    send_last  <= next_item.last;
                    send_wait = pick_gap(send_burst);
                end
            end
        end
    end

    // output ready pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_active || recv_wait != 0)
            begin
                recv_ready <= 1'b0;
                if (!hold_active)
                    recv_wait--;
            end
            else
            begin
                recv_ready <= 1'b1;
                recv_wait = pick_gap(recv_burst);
            end
        end
    end

    initial
    begin
        forever
        begin
            @(hold_go);
            @(posedge clk);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        codec_result_t want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("transfer with nothing pending, out_byte", 0, out_bus.out_byte);
            else
            begin
                want = pending_results.pop_front();
                if (out_bus.out_byte !== want.value)
                    report_mismatch("out_byte", want.value, out_bus.out_byte);
                if (out_bus.out_last !== want.last)
                    report_mismatch("out_last", want.last, out_bus.out_last);
                if (out_bus.status !== want.status)
                    report_mismatch("status", want.status, out_bus.status);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MODE)
            cur_mode = val[0];
        else
            cur_pad = val;
    endtask

    task automatic configure(input bit mode, input logic [5:0] pad);
        write_reg(CFG_MODE, CFG_DATA_W'(mode));
        write_reg(CFG_PAD, pad);
        @(negedge clk);
    endtask

    function automatic void queue_frame(input byte_q_t f);
        foreach (f[i])
            pending_bytes.insert(pending_bytes.size(),
                                 stream_byte_t'{f[i], i == f.size() - 1});
    endfunction

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || send_valid || pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // payload length: mostly short, now and then up to the largest that still fits
    function automatic int unsigned pick_len(input int unsigned lo);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(lo, lo + 6);
        if (r < 9)
            return $urandom_range(lo, 20);
        return FRAME_MAX - 3;
    endfunction

    function automatic void encode_stimulus(output byte_q_t f);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 17)
            rand_bytes(pick_len(1), f);
        else if (r < 19)
            rand_bytes($urandom_range(FRAME_MAX - 2, FRAME_MAX), f);
        else
            rand_bytes($urandom_range(FRAME_MAX + 1, FRAME_MAX + 8), f);
    endfunction

    // Mostly well-formed frames; the rest are damaged in one place, too small, or plain noise.
    function automatic void decode_stimulus(output byte_q_t f);
        byte_q_t     p;
        int unsigned n, pad, kind, pos, dlen;
        kind = $urandom_range(0, 99);
        n = pick_len(4);
        rand_bytes(n, p);
        p[2] = BYTE_FE;
        pad = ($urandom_range(0, 2) == 0) ? $urandom_range(0, FRAME_MAX) : 0;
        build_frame(p, pad, f);
        if (kind < 55)
            return;
        if (kind < 61)
            f[1] ^= 8'($urandom_range(1, 255));
        else if (kind < 67)
            f[0] = 8'($urandom_range(0, 255));
        else if (kind < 73)
        begin
            if (f.size() > n + 3)
                f[$urandom_range(n + 3, f.size() - 1)] = 8'($urandom_range(1, 255));
            else
                f.insert(f.size(), 8'($urandom_range(1, 255)));
        end
        else if (kind < 79)
        begin
            dlen = $urandom_range(1, 5);
            f.delete();
            f.insert(f.size(), 8'(dlen));
            f.insert(f.size(), BYTE_MARKER);
            for (int unsigned i = 2; i <= dlen; i++)
                f.insert(f.size(), 8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 3))
                f.insert(f.size(), BYTE_ZERO);
        end
        else if (kind < 85)
            f[4] ^= 8'($urandom_range(1, 255));
        else if (kind < 91)
        begin
            pos = $urandom_range(2, n + 2);
            if (pos == 4)
                pos = 5;
            f[pos] ^= 8'($urandom_range(1, 255));
        end
        else if (kind < 94)
            rand_bytes(1, f);
        else if (kind < 97)
            rand_bytes($urandom_range(FRAME_MAX + 1, FRAME_MAX + 8), f);
        else
            rand_bytes($urandom_range(2, 20), f);
    endfunction

    initial
    begin : stimulus
        byte_q_t     f, p;
        int unsigned random_sent, phase_bytes, phase;
        logic [5:0]  pad;
        bit          mode;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // encode: smallest payload, checksum inside the keyed region, pad to the cap
        configure(MODE_ENCODE, 6'd0);
        queue_frame('{8'h00});
        queue_frame('{8'hFF, 8'h80, 8'h7F, 8'h01});
        wait_drained();
        configure(MODE_ENCODE, 6'd63);
        queue_frame('{8'h5A});
        wait_drained();

        // decode: short, marker, length, small, padding, then a clean frame
        configure(MODE_DECODE, 6'd32);
        queue_frame('{8'h07});
        queue_frame('{8'h06, 8'h02});
        queue_frame('{8'h08, 8'h01, 8'h00});
        queue_frame('{8'h02, 8'h01, 8'h00});
        queue_frame('{8'h02, 8'h01, 8'h00, 8'h05});
        p = '{8'h3C, 8'h11, 8'hFE, 8'h80};
        build_frame(p, 0, f);
        queue_frame(f);
        wait_drained();

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            mode = (phase == 0) ? MODE_ENCODE : bit'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0:       pad = 6'd0;
                1:       pad = 6'd32;
                2:       pad = 6'd63;
                default: pad = 6'($urandom_range(0, 63));
            endcase
            configure(mode, pad);
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            if (phase == 1)
                -> hold_go;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                if (mode == MODE_DECODE)
                    decode_stimulus(f);
                else
                    encode_stimulus(f);
                queue_frame(f);
                phase_bytes += f.size();
            end
            random_sent += phase_bytes;
            wait_drained();
            phase++;
        end

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[%0t] run exceeded its cycle limit", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/afxc_pkg.sv
hdl/afxc_if.sv
hdl/adv_frame_xor_codec.sv
bench/tb_adv_frame_xor_codec.sv
